@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned ADDR_W  = 12;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_LAZY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FLD_LEFT  = 2'd0,
    FLD_RIGHT = 2'd1,
    FLD_FREE  = 2'd2
  } fld_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_ALC_RD,
    ST_ALC_CHK,
    ST_ALC_WQ,
    ST_ALC_FIN,
    ST_LAZY,
    ST_FL_RD,
    ST_FL_GET,
    ST_REL_START,
    ST_REL_L0,
    ST_REL_L1,
    ST_REL_L2,
    ST_REL_L3,
    ST_REL_L4,
    ST_REL_L5,
    ST_REL_L6,
    ST_REL_R0,
    ST_REL_R1,
    ST_REL_R2,
    ST_REL_R3,
    ST_REL_R4,
    ST_REL_R5,
    ST_REL_FIN,
    ST_REL_END,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_addr;
  } ffha_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] payload_addr;
  } ffha_rsp_t;

endpackage
`default_nettype wire

@@ rtl/ffha_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface ffha_req_if;
  logic                           valid;
  logic                           ready;
  logic [ffha_pkg::KIND_W-1:0]    kind;
  logic [ffha_pkg::BYTES_W-1:0]   request_bytes;
  logic [ffha_pkg::ADDR_W-1:0]    block_addr;
  modport source (output valid, kind, request_bytes, block_addr, input ready);
  modport sink (input valid, kind, request_bytes, block_addr, output ready);
endinterface

interface ffha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [ffha_pkg::ADDR_W-1:0] payload_addr;
  modport source (output valid, ok, payload_addr, input ready);
  modport sink (input valid, ok, payload_addr, output ready);
endinterface
`default_nettype wire

@@ rtl/ffha_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffha_div #(
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ffha_pkg::BYTES_W-1:0] dividend_i,
  output logic                         done_o,
  output logic [ffha_pkg::BYTES_W-1:0] quotient_o
);
  import ffha_pkg::*;

  // reciprocal multiply: q = (x * m) >> (BYTES_W + SH), m = 2^(BYTES_W+SH)/d + 1
  localparam int unsigned SH = $clog2(UNIT_BYTES);
  localparam int unsigned PW = 2 * BYTES_W + 1;
  localparam logic [63:0] RECIP = ((64'd1 << (BYTES_W + SH)) / 64'(UNIT_BYTES)) + 64'd1;
  localparam logic [BYTES_W:0] MULT = RECIP[BYTES_W:0];

  logic                 done_q, done_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [2*BYTES_W-1:0] prod_lo;

  assign prod_lo = {{BYTES_W{1'b0}}, dividend_i} *
                   {{BYTES_W{1'b0}}, MULT[BYTES_W-1:0]};

  always_comb begin
    done_d = start_i;
    prod_d = prod_q;
    if (start_i) begin
      prod_d = {1'b0, prod_lo} +
               (MULT[BYTES_W] ? {1'b0, dividend_i, {BYTES_W{1'b0}}} : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign done_o     = done_q;
  assign quotient_o = BYTES_W'(prod_q >> (BYTES_W + SH));

endmodule
`default_nettype wire

@@ rtl/ffha_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl #(
  parameter int unsigned ARENA_UNITS = 4096,
  parameter int unsigned UNIT_BYTES  = 16,
  parameter int unsigned LAZY_SLOTS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ffha_pkg::ffha_req_t req_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ffha_pkg::ffha_rsp_t res_o
);
  import ffha_pkg::*;

  localparam int unsigned AW  = $clog2(ARENA_UNITS);
  localparam int unsigned EW  = 2 * AW + 1;
  localparam int unsigned SW  = $clog2(ARENA_UNITS + 1);
  localparam int unsigned CW  = $clog2(LAZY_SLOTS + 1);
  localparam int unsigned LIW = (LAZY_SLOTS > 1) ? $clog2(LAZY_SLOTS) : 1;
  localparam int unsigned XW  = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam int unsigned WW  = BYTES_W + 1;
  localparam logic [AW-1:0] TOP = AW'(ARENA_UNITS - 1);

  function automatic logic in_arena(input logic [AW-1:0] a);
    return {1'b0, a} < (AW+1)'(ARENA_UNITS);
  endfunction

  logic [EW-1:0]     unit_mem [ARENA_UNITS];
  logic [ADDR_W-1:0] lz_mem   [LAZY_SLOTS];
  logic [EW-1:0]     rdata_q;
  logic [ADDR_W-1:0] lz_rdata_q;

  state_e            state_q, state_d;
  state_e            ret_q, ret_d;
  fld_e              fld_q, fld_d;
  logic [AW-1:0]     rmw_addr_q, rmw_addr_d;
  logic [AW-1:0]     rmw_val_q, rmw_val_d;
  logic [AW-1:0]     p_q, p_d, q_q, q_d, pr_q, pr_d;
  logic [SW-1:0]     steps_q, steps_d;
  logic [WW-1:0]     want_q, want_d;
  logic [CW-1:0]     lz_cnt_q, lz_cnt_d;
  logic [CW-1:0]     fl_idx_q, fl_idx_d;
  logic              flush_q, flush_d;
  logic              rel_ok_q, rel_ok_d;
  logic [ADDR_W-1:0] rel_addr_q, rel_addr_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  ffha_rsp_t         res_q, res_d;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [EW-1:0]     wr_data;
  logic              lz_we;
  logic [LIW-1:0]    lz_waddr, lz_raddr;

  logic              div_start, div_done;
  logic [BYTES_W-1:0] div_quo;

  logic [AW-1:0]     rd_left, rd_right, size;
  logic              rd_free;
  logic [XW-1:0]     addr_x;
  logic [XW-1:0]     pay_x;

  assign rd_left  = rdata_q[EW-1 -: AW];
  assign rd_right = rdata_q[AW:1];
  assign rd_free  = rdata_q[0];
  assign size     = (rd_right > p_q && in_arena(rd_right)) ? rd_right - p_q : '0;
  assign addr_x   = XW'(rel_addr_q) - XW'(1);
  assign pay_x    = XW'(p_q) + XW'(1);

  ffha_div #(.UNIT_BYTES(UNIT_BYTES)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((bytes_q == '0) ? '0 : bytes_q - BYTES_W'(1)),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    fld_d      = fld_q;
    rmw_addr_d = rmw_addr_q;
    rmw_val_d  = rmw_val_q;
    p_d        = p_q;
    q_d        = q_q;
    pr_d       = pr_q;
    steps_d    = steps_q;
    want_d     = want_q;
    lz_cnt_d   = lz_cnt_q;
    fl_idx_d   = fl_idx_q;
    flush_d    = flush_q;
    rel_ok_d   = rel_ok_q;
    rel_addr_d = rel_addr_q;
    bytes_d    = bytes_q;
    kind_d     = kind_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    rd_addr    = '0;
    lz_we      = 1'b0;
    lz_waddr   = lz_cnt_q[LIW-1:0];
    lz_raddr   = fl_idx_q[LIW-1:0];
    div_start  = 1'b0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = p_q;
        wr_data = (p_q == '0) ? {AW'(0), TOP, 1'b1} : '0;
        p_d     = p_q + AW'(1);
        if (p_q == TOP) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d     = req_i.kind;
          bytes_d    = req_i.request_bytes;
          rel_addr_d = req_i.block_addr;
          flush_d    = 1'b0;
          case (kind_e'(req_i.kind))
            KIND_ALLOC: state_d = ST_DIV;
            KIND_FREE:  state_d = ST_REL_START;
            KIND_LAZY:  state_d = ST_LAZY;
            default: begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (kind_q == KIND_ALLOC && !div_done && steps_q == SW'(ARENA_UNITS)) begin
          div_start = 1'b1;
          steps_d   = '0;
        end else if (div_done) begin
          want_d  = WW'(div_quo) + WW'(2);
          p_d     = '0;
          steps_d = '0;
          state_d = ST_ALC_RD;
        end
      end
      ST_ALC_RD: begin
        rd_addr = p_q;
        if (steps_q == SW'(ARENA_UNITS) || p_q >= TOP) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ALC_CHK;
        end
      end
      ST_ALC_CHK: begin
        if (rd_free && WW'(size) >= want_q) begin
          wr_en   = 1'b1;
          wr_addr = p_q;
          if (WW'(size) > want_q) begin
            q_d     = p_q + want_q[AW-1:0];
            pr_d    = rd_right;
            wr_data = {rd_left, p_q + want_q[AW-1:0], 1'b0};
            state_d = ST_ALC_WQ;
          end else begin
            wr_data = {rd_left, rd_right, 1'b0};
            state_d = ST_ALC_FIN;
          end
        end else begin
          p_d     = rd_right;
          steps_d = steps_q + SW'(1);
          state_d = ST_ALC_RD;
        end
      end
      ST_ALC_WQ: begin
        wr_en      = 1'b1;
        wr_addr    = q_q;
        wr_data    = {p_q, pr_q, 1'b1};
        rmw_addr_d = pr_q;
        fld_d      = FLD_LEFT;
        rmw_val_d  = q_q;
        ret_d      = ST_ALC_FIN;
        state_d    = ST_RMW_RD;
      end
      ST_ALC_FIN: begin
        res_d.ok           = 1'b1;
        res_d.payload_addr = pay_x[ADDR_W-1:0];
        state_d            = ST_DONE;
      end
      ST_LAZY: begin
        if (lz_cnt_q < CW'(LAZY_SLOTS)) begin
          lz_we    = 1'b1;
          lz_cnt_d = lz_cnt_q + CW'(1);
          res_d    = '{ok: 1'b1, payload_addr: '0};
          state_d  = ST_DONE;
        end else begin
          lz_cnt_d = '0;
          fl_idx_d = '0;
          flush_d  = 1'b1;
          state_d  = ST_REL_START;
        end
      end
      ST_FL_RD: begin
        fl_idx_d = fl_idx_q + CW'(1);
        state_d  = ST_FL_GET;
      end
      ST_FL_GET: begin
        rel_addr_d = lz_rdata_q;
        state_d    = ST_REL_START;
      end
      ST_REL_START: begin
        if (rel_addr_q == '0) begin
          rel_ok_d = 1'b1;
          state_d  = ST_REL_END;
        end else if (addr_x >= XW'(TOP)) begin
          rel_ok_d = 1'b0;
          state_d  = ST_REL_END;
        end else begin
          rel_ok_d   = 1'b1;
          p_d        = addr_x[AW-1:0];
          rmw_addr_d = addr_x[AW-1:0];
          fld_d      = FLD_FREE;
          rmw_val_d  = '0;
          ret_d      = ST_REL_L0;
          state_d    = ST_RMW_RD;
        end
      end
      ST_REL_L0: begin
        rd_addr = p_q;
        state_d = (p_q != '0) ? ST_REL_L1 : ST_REL_R0;
      end
      ST_REL_L1: begin
        q_d     = rd_left;
        pr_d    = rd_right;
        state_d = in_arena(rd_left) ? ST_REL_L2 : ST_REL_R0;
      end
      ST_REL_L2: begin
        rd_addr = q_q;
        state_d = ST_REL_L3;
      end
      ST_REL_L3: begin
        if (rd_free) begin
          rmw_addr_d = q_q;
          fld_d      = FLD_RIGHT;
          rmw_val_d  = pr_q;
          ret_d      = ST_REL_L4;
          state_d    = ST_RMW_RD;
        end else begin
          state_d = ST_REL_R0;
        end
      end
      ST_REL_L4: begin
        rmw_addr_d = q_q;
        fld_d      = FLD_FREE;
        rmw_val_d  = AW'(1);
        ret_d      = ST_REL_L5;
        state_d    = ST_RMW_RD;
      end
      ST_REL_L5: begin
        if (in_arena(pr_q)) begin
          rmw_addr_d = pr_q;
          fld_d      = FLD_LEFT;
          rmw_val_d  = q_q;
          ret_d      = ST_REL_L6;
          state_d    = ST_RMW_RD;
        end else begin
          state_d = ST_REL_L6;
        end
      end
      ST_REL_L6: begin
        p_d     = q_q;
        state_d = ST_REL_R0;
      end
      ST_REL_R0: begin
        rd_addr = p_q;
        state_d = (p_q != TOP) ? ST_REL_R1 : ST_REL_FIN;
      end
      ST_REL_R1: begin
        q_d     = rd_right;
        state_d = in_arena(rd_right) ? ST_REL_R2 : ST_REL_FIN;
      end
      ST_REL_R2: begin
        rd_addr = q_q;
        state_d = ST_REL_R3;
      end
      ST_REL_R3: begin
        if (rd_free) begin
          pr_d       = rd_right;
          rmw_addr_d = p_q;
          fld_d      = FLD_RIGHT;
          rmw_val_d  = rd_right;
          ret_d      = ST_REL_R4;
          state_d    = ST_RMW_RD;
        end else begin
          state_d = ST_REL_FIN;
        end
      end
      ST_REL_R4: begin
        if (in_arena(pr_q)) begin
          rmw_addr_d = pr_q;
          fld_d      = FLD_LEFT;
          rmw_val_d  = p_q;
          ret_d      = ST_REL_R5;
          state_d    = ST_RMW_RD;
        end else begin
          state_d = ST_REL_R5;
        end
      end
      ST_REL_R5: begin
        rmw_addr_d = q_q;
        fld_d      = FLD_FREE;
        rmw_val_d  = AW'(1);
        ret_d      = ST_REL_FIN;
        state_d    = ST_RMW_RD;
      end
      ST_REL_FIN: begin
        rmw_addr_d = p_q;
        fld_d      = FLD_FREE;
        rmw_val_d  = AW'(1);
        ret_d      = ST_REL_END;
        state_d    = ST_RMW_RD;
      end
      ST_REL_END: begin
        if (!flush_q) begin
          res_d   = '{ok: rel_ok_q, payload_addr: '0};
          state_d = ST_DONE;
        end else if (fl_idx_q == CW'(LAZY_SLOTS)) begin
          res_d   = '{ok: 1'b1, payload_addr: '0};
          state_d = ST_DONE;
        end else begin
          state_d = ST_FL_RD;
        end
      end
      ST_RMW_RD: begin
        rd_addr = rmw_addr_q;
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        wr_en   = 1'b1;
        wr_addr = rmw_addr_q;
        wr_data = rdata_q;
        case (fld_q)
          FLD_LEFT:  wr_data[EW-1 -: AW] = rmw_val_q;
          FLD_RIGHT: wr_data[AW:1]       = rmw_val_q;
          default:   wr_data[0]          = rmw_val_q[0];
        endcase
        state_d = ret_q;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // divider kicks off on the first ST_DIV cycle (steps parked at the arena size)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      ret_q    <= ST_IDLE;
      fld_q    <= FLD_LEFT;
      p_q      <= '0;
      steps_q  <= SW'(ARENA_UNITS);
      lz_cnt_q <= '0;
      fl_idx_q <= '0;
      flush_q  <= 1'b0;
      rel_ok_q <= 1'b0;
      kind_q   <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      fld_q    <= fld_d;
      p_q      <= p_d;
      steps_q  <= (state_q == ST_DONE) ? SW'(ARENA_UNITS) : steps_d;
      lz_cnt_q <= lz_cnt_d;
      fl_idx_q <= fl_idx_d;
      flush_q  <= flush_d;
      rel_ok_q <= rel_ok_d;
      kind_q   <= kind_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rmw_addr_q <= rmw_addr_d;
    rmw_val_q  <= rmw_val_d;
    q_q        <= q_d;
    pr_q       <= pr_d;
    want_q     <= want_d;
    rel_addr_q <= rel_addr_d;
    bytes_q    <= bytes_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) unit_mem[wr_addr] <= wr_data;
    rdata_q <= unit_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lz_we) lz_mem[lz_waddr] <= rel_addr_q;
    lz_rdata_q <= lz_mem[lz_raddr];
  end

  assign res_o = res_q;

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> wr_addr <= TOP)
    else $error("unit write beyond arena");

  a_lz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lz_cnt_q <= CW'(LAZY_SLOTS))
    else $error("lazy count overflow");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.ok |-> res_o.payload_addr == '0)
    else $error("failed transaction with nonzero payload");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ALC_CHK |=> state_q != ST_ALC_CHK)
    else $error("walk check repeated");

  a_flush_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> fl_idx_q <= CW'(LAZY_SLOTS))
    else $error("flush index overflow");

endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator over an arena of ARENA_UNITS header units.
// req_i carries kind (allocate, free, lazy free), request_bytes and
// block_addr; rsp_o returns ok and payload_addr, one transaction per request.
// Requests are taken one at a time; the chunk chain lives in a single-port
// read / single-port write unit memory with a registered read, and every
// update of an existing entry is a read-modify-write of that one entry.
// Allocate: the request is sized by a reciprocal multiply, the walk reads and
// checks each chunk it visits, then the chunk found is split and replied.
// Free: a null or out-of-range address needs no merge; otherwise the work
// depends on which neighbors merge.
// Lazy free: the address is stored while the holder has room; when it is
// full a flush runs LAZY_SLOTS + 1 frees back to back.
// After reset the unit memory is swept once before req_i.ready rises. A
// result sits in an output register, so the next request is processed while
// the sink stalls; it completes into that register once the previous result
// has been taken.
module first_fit_heap_allocator #(
  parameter int unsigned ARENA_UNITS = 4096,
  parameter int unsigned UNIT_BYTES  = 16,
  parameter int unsigned LAZY_SLOTS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_req_if.sink   req_i,
  ffha_rsp_if.source rsp_o
);
  import ffha_pkg::*;

  ffha_req_t req;
  ffha_rsp_t res;
  logic      res_valid, res_ready;
  logic      out_valid_q;
  ffha_rsp_t out_q;

  assign req = '{kind: req_i.kind, request_bytes: req_i.request_bytes,
                 block_addr: req_i.block_addr};

  ffha_ctrl #(
    .ARENA_UNITS (ARENA_UNITS),
    .UNIT_BYTES  (UNIT_BYTES),
    .LAZY_SLOTS  (LAZY_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.ok           = out_q.ok;
  assign rsp_o.payload_addr = out_q.payload_addr;

endmodule
`default_nettype wire
